[design/dhcp_pkg.sv]
// Package with shared types and constants of the DHCP client controller.
package dhcp_pkg;

   localparam int MaxMessageBytesDefault = 1024;

   typedef enum logic [2:0] {
      REQ_BYTE    = 3'd0,
      REQ_TICK    = 3'd1,
      REQ_GET     = 3'd2,
      REQ_RENEW   = 3'd3,
      REQ_RELEASE = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE            = 3'd0,
      ST_GETLEASE        = 3'd1,
      ST_DISCOVERING     = 3'd2,
      ST_REQUESTING      = 3'd3,
      ST_CONFIGURED      = 3'd4,
      ST_RENEW_PENDING   = 3'd5,
      ST_RELEASE_PENDING = 3'd6,
      ST_RELEASE_SENT    = 3'd7
   } client_state_type;

   localparam logic [1:0] TX_NONE     = 2'd0;
   localparam logic [1:0] TX_DISCOVER = 2'd1;
   localparam logic [1:0] TX_REQUEST  = 2'd2;
   localparam logic [1:0] TX_RELEASE  = 2'd3;

   localparam logic [1:0] UPD_NONE    = 2'd0;
   localparam logic [1:0] UPD_NEW     = 2'd1;
   localparam logic [1:0] UPD_CLEARED = 2'd2;

   localparam logic [2:0] CSR_MAC       = 3'd0;
   localparam logic [2:0] CSR_XID       = 3'd1;
   localparam logic [2:0] CSR_RETRY     = 3'd2;
   localparam logic [2:0] CSR_RESENDS   = 3'd3;
   localparam logic [2:0] CSR_THRESHOLD = 3'd4;
   localparam logic [2:0] CSR_TPS       = 3'd5;

   localparam logic [7:0] MSG_OFFER = 8'd2;
   localparam logic [7:0] MSG_ACK   = 8'd5;
   localparam logic [7:0] OPT_MASK   = 8'd1;
   localparam logic [7:0] OPT_ROUTER = 8'd3;
   localparam logic [7:0] OPT_LEASE  = 8'd51;
   localparam logic [7:0] OPT_TYPE   = 8'd53;
   localparam logic [7:0] OPT_SERVER = 8'd54;
   localparam logic [7:0] OPT_END    = 8'd255;
   localparam logic [7:0] BOOT_REPLY = 8'd2;

   localparam int OptionsStart = 240;
   localparam int HeaderEnd    = 34;

   // Lease field set, in the order ip, mask, router, server id, lease.
   typedef struct packed {
      logic [31:0] ip;
      logic [31:0] mask;
      logic [31:0] router;
      logic [31:0] server;
      logic [31:0] lease;
   } fields_type;

   // Classified request passed from the parser to the client engine.
   typedef struct packed {
      req_code_type kind;
      logic         reply_end;
      logic         reply_ok;
      logic [7:0]   reply_type;
      fields_type   shadow;
   } event_type;

endpackage

[design/dhcp_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface dhcp_req_if import dhcp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, req_type, data_byte, last_byte, input ready);
   modport sink (input valid, req_type, data_byte, last_byte, output ready);
endinterface

interface dhcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  send_kind;
   logic [1:0]  update_kind;
   logic        running;
   logic        lease_held;
   logic [31:0] ip_address;
   logic [31:0] subnet_mask;
   logic [31:0] router_address;
   logic [31:0] server_id;
   logic [31:0] lease_seconds;
   modport source (output valid, send_kind, update_kind, running, lease_held, ip_address,
      subnet_mask, router_address, server_id, lease_seconds, input ready);
   modport sink (input valid, send_kind, update_kind, running, lease_held, ip_address,
      subnet_mask, router_address, server_id, lease_seconds, output ready);
endinterface

[design/dhcp_parser.sv]
// Front end: parses reply bytes into a shadow field set and classifies requests.
module dhcp_parser import dhcp_pkg::*; #(
   parameter int MaxMessageBytes = MaxMessageBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [2:0]  in_type,
   input  logic [7:0]  in_byte,
   input  logic        in_last,
   input  logic [47:0] mac_address,
   input  logic [31:0] transaction_id,
   input  fields_type  lease_fields,
   input  logic        take_lease,
   input  fields_type  lease_next,
   output logic        ev_valid,
   output event_type   ev_data
);
   localparam int OffW = $clog2(MaxMessageBytes + 2);

   logic [OffW-1:0] off_ff, off_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] code_ff, code_in, remain_ff, remain_in, rtype_ff, rtype_in;
   logic [2:0] vidx_ff, vidx_in;
   logic       hok_ff, hok_in, end_ff, end_in;
   fields_type shadow_ff, shadow_in;

   logic       first;
   fields_type base;
   logic [OffW-1:0] off_inc;
   logic [1:0] bsel;

   always_comb begin
      first     = (off_ff == '0);
      base      = first ? (take_lease ? lease_next : lease_fields) : shadow_ff;
      off_in    = off_ff;
      phase_in  = first ? 2'd0 : phase_ff;
      code_in   = first ? 8'd0 : code_ff;
      remain_in = first ? 8'd0 : remain_ff;
      vidx_in   = first ? 3'd0 : vidx_ff;
      hok_in    = first ? 1'b1 : hok_ff;
      rtype_in  = first ? 8'd0 : rtype_ff;
      end_in    = first ? 1'b0 : end_ff;
      shadow_in = base;
      off_inc   = off_ff + OffW'(1);
      bsel      = 2'(off_ff) ;
      if (in_valid && in_type == REQ_BYTE) begin
         if (off_ff < OffW'(MaxMessageBytes)) begin
            off_in = off_inc;
            if (off_ff < OffW'(OptionsStart)) begin
               // Fixed header checks and the offered address.
               if (off_ff == '0 && in_byte != BOOT_REPLY) hok_in = 1'b0;
               if (off_ff >= OffW'(4) && off_ff <= OffW'(7) &&
                   in_byte != transaction_id[8*(3-(2'(off_ff)))+:8]) hok_in = 1'b0;
               if (off_ff >= OffW'(16) && off_ff <= OffW'(19))
                  shadow_in.ip[8*(3-bsel)+:8] = in_byte;
               if (off_ff >= OffW'(28) && off_ff <= OffW'(33) &&
                   in_byte != mac_address[8*(5-3'(off_ff - OffW'(28)))+:8]) hok_in = 1'b0;
            end else if (!end_in) begin
               // Option walk: code, length, value bytes.
               unique case (phase_in)
                  2'd0: begin
                     code_in = in_byte;
                     if (in_byte == OPT_END) end_in = 1'b1;
                     else phase_in = 2'd1;
                  end
                  2'd1: begin
                     remain_in = in_byte;
                     vidx_in   = 3'd0;
                     phase_in  = (in_byte == 8'd0) ? 2'd0 : 2'd2;
                  end
                  default: begin
                     if (!vidx_in[2]) begin
                        priority case (code_in)
                           OPT_MASK:   shadow_in.mask[8*(3-vidx_in[1:0])+:8] = in_byte;
                           OPT_ROUTER: shadow_in.router[8*(3-vidx_in[1:0])+:8] = in_byte;
                           OPT_SERVER: shadow_in.server[8*(3-vidx_in[1:0])+:8] = in_byte;
                           OPT_LEASE:  shadow_in.lease[8*(3-vidx_in[1:0])+:8] = in_byte;
                           OPT_TYPE:   if (vidx_in == 3'd0) rtype_in = in_byte;
                           default: ;
                        endcase
                        vidx_in = vidx_in + 3'd1;
                     end
                     remain_in = remain_in - 8'd1;
                     if (remain_in == 8'd0) phase_in = 2'd0;
                  end
               endcase
            end
         end
         if (in_last) off_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= '0; phase_ff <= '0; code_ff <= '0; remain_ff <= '0;
         vidx_ff <= '0; hok_ff <= 1'b1; rtype_ff <= '0; end_ff <= 1'b0;
         shadow_ff <= '0; ev_valid <= 1'b0;
      end else begin
         if (in_valid && in_type == REQ_BYTE) begin
            off_ff <= off_in; phase_ff <= phase_in; code_ff <= code_in;
            remain_ff <= remain_in; vidx_ff <= vidx_in; hok_ff <= hok_in;
            rtype_ff <= rtype_in; end_ff <= end_in; shadow_ff <= shadow_in;
         end
         ev_valid <= in_valid;
      end
   end

   // Classified request to the engine. A reply counts as long enough when the
   // offset after its last byte reaches the end of the checked header.
   always_ff @(posedge clock) begin
      if (in_valid) begin
         ev_data.kind       <= req_code_type'(in_type);
         ev_data.reply_end  <= in_type == REQ_BYTE && in_last;
         ev_data.reply_ok   <= in_type == REQ_BYTE && in_last && hok_in &&
            off_inc >= OffW'(HeaderEnd);
         ev_data.reply_type <= (hok_in && end_in) ? rtype_in : 8'd0;
         ev_data.shadow     <= shadow_in;
      end
   end
endmodule

[design/dhcp_engine.sv]
// Back end: client state machine, timers and lease countdown.
module dhcp_engine import dhcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        ev_valid,
   input  event_type   ev_data,
   input  logic [3:0]  retry_ticks,
   input  logic [3:0]  max_request_resends,
   input  logic [15:0] renew_threshold_seconds,
   input  logic [3:0]  ticks_per_second,
   output fields_type  lease_fields,
   output logic        take_lease,
   output fields_type  lease_next,
   output logic        out_valid,
   output logic [1:0]  out_send,
   output logic [1:0]  out_upd,
   output client_state_type out_state
);
   client_state_type st_ff, st_in;
   logic [3:0] tick_ff, tick_in, resend_ff, resend_in, pre_ff, pre_in;
   fields_type lease_ff, lease_in;
   logic [1:0] send, upd;
   logic       reply, act;

   assign lease_fields = lease_ff;
   assign lease_next   = lease_in;
   assign take_lease   = ev_valid;

   always_comb begin
      st_in = st_ff; tick_in = tick_ff; resend_in = resend_ff; pre_in = pre_ff;
      lease_in = lease_ff; send = TX_NONE; upd = UPD_NONE;
      reply = ev_data.kind == REQ_BYTE;
      // Poll ticks and the last byte of every reply activate the client.
      act = ev_valid && (ev_data.kind == REQ_TICK || ev_data.reply_end);
      if (ev_valid) begin
         if (ev_data.reply_ok && (st_ff == ST_DISCOVERING || st_ff == ST_REQUESTING))
            lease_in = ev_data.shadow;
      end
      if (act) begin
         unique case (st_ff)
            ST_GETLEASE: begin
               st_in = ST_DISCOVERING; send = TX_DISCOVER; tick_in = '0;
            end
            ST_DISCOVERING: begin
               if (reply) begin
                  if (ev_data.reply_type == MSG_OFFER) begin
                     st_in = ST_REQUESTING; send = TX_REQUEST; resend_in = '0;
                  end else send = TX_DISCOVER;
                  tick_in = '0;
               end else begin
                  tick_in = tick_ff + 4'd1;
                  if (tick_in == retry_ticks) begin
                     send = TX_DISCOVER; tick_in = '0;
                  end
               end
            end
            ST_REQUESTING: begin
               if (reply) begin
                  if (ev_data.reply_type == MSG_ACK) begin
                     st_in = ST_CONFIGURED; pre_in = '0; upd = UPD_NEW;
                  end else begin
                     st_in = ST_DISCOVERING; send = TX_DISCOVER; tick_in = '0;
                  end
               end else begin
                  tick_in = tick_ff + 4'd1;
                  if (tick_in == retry_ticks) begin
                     resend_in = resend_ff + 4'd1;
                     if (resend_in < max_request_resends) send = TX_REQUEST;
                     else begin
                        st_in = ST_DISCOVERING; send = TX_DISCOVER;
                     end
                     tick_in = '0;
                  end
               end
            end
            ST_CONFIGURED: begin
               if (!reply) begin
                  pre_in = pre_ff + 4'd1;
                  if (pre_in == ticks_per_second) begin
                     if (lease_ff.lease != '0) lease_in.lease = lease_ff.lease - 32'd1;
                     pre_in = '0;
                  end
                  if (lease_in.lease < {16'd0, renew_threshold_seconds}) begin
                     send = TX_REQUEST; resend_in = '0; tick_in = '0;
                     st_in = ST_REQUESTING;
                  end
               end
            end
            ST_RENEW_PENDING: begin
               send = TX_REQUEST; resend_in = '0; tick_in = '0; st_in = ST_REQUESTING;
            end
            ST_RELEASE_PENDING: begin
               send = TX_RELEASE; resend_in = '0; tick_in = '0; st_in = ST_RELEASE_SENT;
            end
            ST_RELEASE_SENT: begin
               lease_in = '0; upd = UPD_CLEARED; st_in = ST_IDLE;
            end
            default: ;
         endcase
      end else if (ev_valid) begin
         // Commands; reply bytes before the last one change nothing here.
         priority case (ev_data.kind)
            REQ_GET: if (st_ff == ST_IDLE || st_ff == ST_RELEASE_SENT) st_in = ST_GETLEASE;
            REQ_RENEW: if (st_ff == ST_CONFIGURED) st_in = ST_RENEW_PENDING;
            REQ_RELEASE: if (st_ff == ST_CONFIGURED) st_in = ST_RELEASE_PENDING;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; tick_ff <= '0; resend_ff <= '0; pre_ff <= '0;
         lease_ff <= '0; out_valid <= 1'b0;
      end else begin
         st_ff <= st_in; tick_ff <= tick_in; resend_ff <= resend_in; pre_ff <= pre_in;
         lease_ff <= lease_in; out_valid <= ev_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_send  <= send;
      out_upd   <= upd;
      out_state <= st_in;
   end
endmodule

[design/dhcp_client_controller.sv]
// Top level of the DHCP client controller.
//
// Requests enter on req (valid/ready): reply bytes, poll ticks, and get-lease,
// renew and release commands. Every request gives exactly one response on rsp
// with the message to send, the lease update and the held lease fields.
// The parser front end classifies a request and registers it, the client
// engine acts on it in the next cycle and registers its result, and that
// result is then written into the response queue. One request is taken every
// cycle while the queue has room for it, as shown by ready.
// The csr port writes the six configuration registers; write only while idle.
// Reset (synchronous, active high) returns the client to idle with the lease
// cleared and the registers at their defaults.
// A stalled receiver is absorbed by a four-entry response queue; ready drops
// when the queue cannot hold the requests still in flight.
module dhcp_client_controller import dhcp_pkg::*; #(
   parameter int MaxMessageBytes = MaxMessageBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   dhcp_req_if.sink    req,
   dhcp_rsp_if.source  rsp,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);
   logic [47:0] mac_ff;
   logic [31:0] xid_ff;
   logic [3:0]  retry_ff, resends_ff, tps_ff;
   logic [15:0] thr_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= '0; xid_ff <= '0; retry_ff <= 4'd6; resends_ff <= 4'd10;
         thr_ff <= 16'd120; tps_ff <= 4'd2;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAC:       mac_ff <= csr_data;
            CSR_XID:       xid_ff <= csr_data[31:0];
            CSR_RETRY:     retry_ff <= csr_data[3:0];
            CSR_RESENDS:   resends_ff <= csr_data[3:0];
            CSR_THRESHOLD: thr_ff <= csr_data[15:0];
            CSR_TPS:       tps_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   logic       accept, ev_valid, take_lease, e_valid;
   event_type  ev_data;
   fields_type lease_fields, lease_next;
   logic [1:0] e_send, e_upd;
   client_state_type e_state;

   assign accept = req.valid && req.ready;

   dhcp_parser #(.MaxMessageBytes(MaxMessageBytes)) u_parser (
      .clock, .reset, .in_valid(accept), .in_type(req.req_type), .in_byte(req.data_byte),
      .in_last(req.last_byte), .mac_address(mac_ff), .transaction_id(xid_ff),
      .lease_fields, .take_lease, .lease_next, .ev_valid, .ev_data);

   dhcp_engine u_engine (
      .clock, .reset, .ev_valid, .ev_data, .retry_ticks(retry_ff),
      .max_request_resends(resends_ff), .renew_threshold_seconds(thr_ff),
      .ticks_per_second(tps_ff), .lease_fields, .take_lease, .lease_next,
      .out_valid(e_valid), .out_send(e_send), .out_upd(e_upd), .out_state(e_state));

   // Response queue.
   localparam int QW = 2 + 2 + 1 + 1 + 5 * 32;
   logic [QW-1:0] q_mem [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff, inflight;
   logic pop;
   fields_type lf;

   assign lf = lease_fields;
   assign pop = rsp.valid && rsp.ready;
   assign inflight = cnt_ff + 3'(ev_valid) + 3'(e_valid);
   assign req.ready = inflight < 3'd4 && !(inflight == 3'd3 && !pop && 1'b0) &&
      (cnt_ff + 3'(ev_valid) + 3'(e_valid) + 3'd1) <= 3'd4;
   assign rsp.valid = cnt_ff != 3'd0;

   always_ff @(posedge clock) begin
      if (e_valid) q_mem[wp_ff] <= {e_send, e_upd,
         1'(e_state != ST_IDLE && e_state != ST_RELEASE_SENT),
         1'(e_state == ST_CONFIGURED), lf.ip, lf.mask, lf.router, lf.server, lf.lease};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (e_valid) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(e_valid) - 3'(pop);
      end
   end

   assign {rsp.send_kind, rsp.update_kind, rsp.running, rsp.lease_held, rsp.ip_address,
      rsp.subnet_mask, rsp.router_address, rsp.server_id, rsp.lease_seconds} = q_mem[rp_ff];

   // The queue never overflows.
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'd4)
      else $error("response queue overflow");
   // Every accepted request reaches the engine in the next cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> ev_valid)
      else $error("lost request");
   // A new-lease update from the engine only comes with the configured state.
   assert property (@(posedge clock) disable iff (reset)
      (e_valid && e_upd == UPD_NEW) |-> e_state == ST_CONFIGURED)
      else $error("new lease outside configured state");
endmodule

[dv/dhcp_tb_if.sv]
`timescale 1ns / 100ps
// Package with constants shared by the testbench files.
package dhcp_tb_pkg;
   localparam int DrainCycles = 8;
endpackage

[dv/dhcp_client_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts DHCP client responses from accepted requests and compares them.
module dhcp_client_checker import dhcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dhcp_req_if         req,
   dhcp_rsp_if         rsp,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [1:0]  send_kind;
      logic [1:0]  update_kind;
      logic        running;
      logic        lease_held;
      fields_type  f;
   } answer_type;

   answer_type answers[$];

   logic [47:0] mac;
   logic [31:0] xid;
   logic [3:0]  retry, resends, tps;
   logic [15:0] threshold;

   client_state_type cstate;
   logic [3:0]  ticks, resend_cnt, prescale;
   int          offset;
   logic [1:0]  phase;
   logic [7:0]  code, remaining, rtype;
   logic [2:0]  vindex;
   logic        hdr_ok, end_seen;
   logic [31:0] shadow[5];
   logic [31:0] lease[5];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [31:0] put(input logic [31:0] w, input int idx, input logic [7:0] b);
      logic [31:0] r;
      r = w;
      r[(3 - idx) * 8 +: 8] = b;
      return r;
   endfunction

   // Walk one reply byte through the header check and option capture.
   task automatic parse(input int off, input logic [7:0] b);
      if (off < OptionsStart) begin
         if (off == 0 && b != BOOT_REPLY) hdr_ok = 0;
         if (off >= 4 && off <= 7 && b != xid[(7 - off) * 8 +: 8]) hdr_ok = 0;
         if (off >= 16 && off <= 19) shadow[0] = put(shadow[0], off - 16, b);
         if (off >= 28 && off <= 33 && b != mac[(33 - off) * 8 +: 8]) hdr_ok = 0;
         return;
      end
      if (end_seen) return;
      if (phase == 0) begin
         code = b;
         if (b == OPT_END) end_seen = 1;
         else phase = 1;
      end else if (phase == 1) begin
         remaining = b;
         vindex = 0;
         phase = (b == 0) ? 0 : 2;
      end else begin
         if (vindex < 4) begin
            case (code)
               OPT_MASK: shadow[1] = put(shadow[1], vindex, b);
               OPT_ROUTER: shadow[2] = put(shadow[2], vindex, b);
               OPT_SERVER: shadow[3] = put(shadow[3], vindex, b);
               OPT_LEASE: shadow[4] = put(shadow[4], vindex, b);
               OPT_TYPE: if (vindex == 0) rtype = b;
               default: ;
            endcase
            vindex++;
         end
         remaining--;
         if (remaining == 0) phase = 0;
      end
   endtask

   // One step of the client engine.
   task automatic activate(input logic has_reply, input logic [7:0] rt,
                           inout logic [1:0] send, inout logic [1:0] upd);
      case (cstate)
         ST_GETLEASE: begin
            cstate = ST_DISCOVERING;
            send = TX_DISCOVER;
            ticks = 0;
         end
         ST_DISCOVERING: begin
            if (has_reply) begin
               if (rt == MSG_OFFER) begin
                  cstate = ST_REQUESTING;
                  send = TX_REQUEST;
                  resend_cnt = 0;
               end else begin
                  send = TX_DISCOVER;
               end
               ticks = 0;
            end else begin
               ticks++;
               if (ticks == retry) begin
                  send = TX_DISCOVER;
                  ticks = 0;
               end
            end
         end
         ST_REQUESTING: begin
            if (has_reply) begin
               if (rt == MSG_ACK) begin
                  cstate = ST_CONFIGURED;
                  prescale = 0;
                  upd = UPD_NEW;
               end else begin
                  cstate = ST_DISCOVERING;
                  send = TX_DISCOVER;
                  ticks = 0;
               end
            end else begin
               ticks++;
               if (ticks == retry) begin
                  resend_cnt++;
                  if (resend_cnt < resends) begin
                     send = TX_REQUEST;
                  end else begin
                     cstate = ST_DISCOVERING;
                     send = TX_DISCOVER;
                  end
                  ticks = 0;
               end
            end
         end
         ST_CONFIGURED: begin
            if (!has_reply) begin
               prescale++;
               if (prescale == tps) begin
                  if (lease[4] != 0) lease[4]--;
                  prescale = 0;
               end
               if (lease[4] < {16'd0, threshold}) begin
                  send = TX_REQUEST;
                  resend_cnt = 0;
                  ticks = 0;
                  cstate = ST_REQUESTING;
               end
            end
         end
         ST_RENEW_PENDING: begin
            send = TX_REQUEST;
            resend_cnt = 0;
            ticks = 0;
            cstate = ST_REQUESTING;
         end
         ST_RELEASE_PENDING: begin
            send = TX_RELEASE;
            resend_cnt = 0;
            ticks = 0;
            cstate = ST_RELEASE_SENT;
         end
         ST_RELEASE_SENT: begin
            for (int i = 0; i < 5; i++) lease[i] = 0;
            upd = UPD_CLEARED;
            cstate = ST_IDLE;
         end
         default: ;
      endcase
   endtask

   // Predict the response to one accepted request.
   task automatic predict(input logic [2:0] kind, input logic [7:0] b, input logic last);
      logic [1:0] send;
      logic [1:0] upd;
      logic       ok;
      logic [7:0] rt;
      answer_type a;
      send = TX_NONE;
      upd = UPD_NONE;
      case (kind)
         REQ_BYTE: begin
            if (offset == 0) begin
               hdr_ok = 1;
               rtype = 0;
               end_seen = 0;
               phase = 0;
               code = 0;
               remaining = 0;
               vindex = 0;
               shadow = lease;
            end
            if (offset < MaxMessageBytesDefault) begin
               parse(offset, b);
               offset++;
            end
            if (last) begin
               ok = hdr_ok && offset >= HeaderEnd;
               rt = (ok && end_seen) ? rtype : 8'd0;
               if (ok && (cstate == ST_DISCOVERING || cstate == ST_REQUESTING)) lease = shadow;
               activate(1, rt, send, upd);
               offset = 0;
            end
         end
         REQ_TICK: activate(0, 0, send, upd);
         REQ_GET: if (cstate == ST_IDLE || cstate == ST_RELEASE_SENT) cstate = ST_GETLEASE;
         REQ_RENEW: if (cstate == ST_CONFIGURED) cstate = ST_RENEW_PENDING;
         REQ_RELEASE: if (cstate == ST_CONFIGURED) cstate = ST_RELEASE_PENDING;
         default: ;
      endcase
      a.send_kind = send;
      a.update_kind = upd;
      a.running = (cstate != ST_IDLE && cstate != ST_RELEASE_SENT);
      a.lease_held = (cstate == ST_CONFIGURED);
      a.f = {lease[0], lease[1], lease[2], lease[3], lease[4]};
      answers.push_back(a);
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         mac = 0; xid = 0; retry = 6; resends = 10; threshold = 120; tps = 2;
         cstate = ST_IDLE;
         ticks = 0; resend_cnt = 0; prescale = 0; offset = 0; phase = 0;
         code = 0; remaining = 0; vindex = 0; hdr_ok = 1; rtype = 0; end_seen = 0;
         for (int i = 0; i < 5; i++) begin
            shadow[i] = 0;
            lease[i] = 0;
         end
         answers.delete();
         errors = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MAC: mac = csr_data;
               CSR_XID: xid = csr_data[31:0];
               CSR_RETRY: retry = csr_data[3:0];
               CSR_RESENDS: resends = csr_data[3:0];
               CSR_THRESHOLD: threshold = csr_data[15:0];
               CSR_TPS: tps = csr_data[3:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (answers.size() == 0) begin
               report("unexpected response", 0, 0);
            end else begin
               want = answers.pop_front();
               if (rsp.send_kind != want.send_kind)
                  report("send_kind", rsp.send_kind, want.send_kind);
               if (rsp.update_kind != want.update_kind)
                  report("update_kind", rsp.update_kind, want.update_kind);
               if (rsp.running != want.running) report("running", rsp.running, want.running);
               if (rsp.lease_held != want.lease_held)
                  report("lease_held", rsp.lease_held, want.lease_held);
               if (rsp.ip_address != want.f.ip) report("ip_address", rsp.ip_address, want.f.ip);
               if (rsp.subnet_mask != want.f.mask)
                  report("subnet_mask", rsp.subnet_mask, want.f.mask);
               if (rsp.router_address != want.f.router)
                  report("router_address", rsp.router_address, want.f.router);
               if (rsp.server_id != want.f.server)
                  report("server_id", rsp.server_id, want.f.server);
               if (rsp.lease_seconds != want.f.lease)
                  report("lease_seconds", rsp.lease_seconds, want.f.lease);
            end
         end
         if (req.valid && req.ready) predict(req.req_type, req.data_byte, req.last_byte);
      end
      pending = answers.size();
   end

endmodule

[dv/dhcp_client_controller_tb.sv]
`timescale 1ns / 100ps
// Testbench top: drives requests and settings into the DHCP client and gives the verdict.
module dhcp_client_controller_tb;
   import dhcp_pkg::*;
   import dhcp_tb_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [2:0]  csr_index = CSR_MAC;
   logic [47:0] csr_data = 0;
   logic        quiet = 0;
   int          errors;
   int          pending;
   int          sent = 0;

   logic [47:0] own_mac;
   logic [31:0] own_xid;

   dhcp_req_if req ();
   dhcp_rsp_if rsp ();

   dhcp_client_controller dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   dhcp_client_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending)
   );

   always #6 clock = ~clock;

   // Receiver stalls in random bursts.
   always @(posedge clock) begin
      int n;
      if (reset || quiet || $urandom_range(0, 3) != 0) begin
         rsp.ready <= 1;
      end else begin
         n = $urandom_range(1, 5);
         rsp.ready <= 0;
         repeat (n - 1) @(posedge clock);
      end
   end

   // Send one request and wait for its acceptance, with an occasional gap first.
   task automatic issue_item(input logic [2:0] kind, input logic [7:0] b,
                             input logic last);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req.valid <= 1;
      req.req_type <= kind;
      req.data_byte <= b;
      req.last_byte <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Present one register write for one cycle; the caller drops the enable.
   task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   // Stream one reply. Mostly well formed: header, then options ending in end.
   task automatic send_reply(input logic [7:0] mtype, input int flaw, input int len_pick);
      logic [7:0] msg[$];
      logic [7:0] b;
      int total;
      msg.delete();
      total = (len_pick == 1) ? int'($urandom_range(1, 40)) : 240;
      for (int i = 0; i < total; i++) begin
         b = (i < 240 && $urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom_range(0, 255));
         if (i == 0) b = BOOT_REPLY;
         if (i >= 4 && i <= 7) b = own_xid[(7 - i) * 8 +: 8];
         if (i >= 28 && i <= 33) b = own_mac[(33 - i) * 8 +: 8];
         msg.push_back(b);
      end
      if (flaw == 1 && total > 7)
         msg[$urandom_range(0, 2) == 0 ? 0 : $urandom_range(4, 7)] ^= 8'h10;
      if (flaw == 2 && total > 33) msg[$urandom_range(28, 33)] ^= 8'h01;
      if (total == 240) begin
         if ($urandom_range(0, 3) == 0) begin
            msg.push_back(8'd0); msg.push_back(8'd0);
         end
         msg.push_back(OPT_MASK); msg.push_back(8'd4);
         repeat (4) msg.push_back(8'($urandom_range(0, 255)));
         msg.push_back(OPT_ROUTER); msg.push_back(8'($urandom_range(0, 6)));
         repeat (msg[$]) msg.push_back(8'($urandom_range(0, 255)));
         msg.push_back(OPT_TYPE); msg.push_back(8'($urandom_range(1, 2)));
         msg.push_back(mtype);
         if (msg[$ - 1] == 2) msg.push_back(8'($urandom_range(0, 255)));
         msg.push_back(OPT_SERVER); msg.push_back(8'd4);
         repeat (4) msg.push_back(8'($urandom_range(0, 255)));
         msg.push_back(OPT_LEASE); msg.push_back(8'd4);
         msg.push_back(8'd0); msg.push_back(8'd0);
         msg.push_back(8'($urandom_range(0, 1))); msg.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 1) begin
            msg.push_back(8'($urandom_range(60, 250))); msg.push_back(8'd2);
            msg.push_back(8'($urandom_range(0, 255)));
            msg.push_back(8'($urandom_range(0, 255)));
         end
         if (flaw != 3) msg.push_back(OPT_END);
         repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
      end
      foreach (msg[i]) issue_item(REQ_BYTE, msg[i], i == msg.size() - 1);
   endtask

   task automatic set_registers(input logic [47:0] m, input logic [31:0] x,
                                input logic [3:0] r, input logic [3:0] rs,
                                input logic [15:0] th, input logic [3:0] t);
      own_mac = m;
      own_xid = x;
      write_reg(CSR_MAC, m);
      write_reg(CSR_XID, {16'd0, x});
      write_reg(CSR_RETRY, {44'd0, r});
      write_reg(CSR_RESENDS, {44'd0, rs});
      write_reg(CSR_THRESHOLD, {32'd0, th});
      write_reg(CSR_TPS, {44'd0, t});
      csr_write <= 0;
   endtask

   // One random request; replies here are short ones that still reach the engine.
   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         issue_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (pick < 40)
         issue_item(REQ_GET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (pick < 46)
         issue_item(REQ_RENEW, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (pick < 51)
         issue_item(REQ_RELEASE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (pick < 54)
         issue_item(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)), 1'b1);
      else if (pick < 68) send_reply(MSG_OFFER, 0, 1);
      else if (pick < 78) send_reply(MSG_ACK, int'($urandom_range(1, 2)), 1);
      else issue_item(REQ_TICK, 8'd0, 1'b0);
   endtask

   // Random requests until about n more items have been accepted.
   task automatic run_items(input int n);
      int stop;
      stop = sent + n;
      while (sent < stop) random_request();
   endtask

   initial begin
      req.valid <= 0;
      req.req_type <= REQ_TICK;
      req.data_byte <= 8'd0;
      req.last_byte <= 1'b0;
      own_mac = 0;
      own_xid = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part with the reset settings: a full lease, renew, release, odd commands.
      issue_item(REQ_RENEW, 8'hff, 1);
      issue_item(REQ_RELEASE, 8'h00, 0);
      issue_item(3'd7, 8'hff, 1);
      issue_item(REQ_GET, 0, 0);
      issue_item(REQ_TICK, 0, 0);
      send_reply(MSG_OFFER, 0, 0);
      send_reply(MSG_ACK, 0, 0);
      issue_item(REQ_TICK, 0, 0);
      issue_item(REQ_RENEW, 0, 0);
      issue_item(REQ_TICK, 0, 0);
      issue_item(REQ_RELEASE, 0, 0);
      issue_item(REQ_TICK, 0, 0);
      issue_item(REQ_TICK, 0, 0);
      drain();

      // Extreme settings: all ones, fast timers with a zero threshold, all zeros.
      set_registers(48'hffff_ffff_ffff, 32'hffff_ffff, 4'd15, 4'd15, 16'hffff, 4'd15);
      run_items(40);
      drain();
      set_registers(48'h0123_4567_89ab, 32'hdead_beef, 4'd1, 4'd1, 16'd0, 4'd1);
      run_items(40);
      drain();
      set_registers(48'h0, 32'h0, 4'd0, 4'd0, 16'd0, 4'd0);
      run_items(40);
      drain();

      // Random settings; the last stretch runs without idling.
      set_registers(48'({$urandom, $urandom}), $urandom, 4'($urandom_range(1, 15)),
                    4'($urandom_range(1, 15)), 16'($urandom_range(0, 300)),
                    4'($urandom_range(1, 15)));
      quiet = 1;
      run_items(40);
      drain();

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
